@@ rtl/cba_pkg.sv @@
// shared types and constants for the contiguous block allocator
package cba_pkg;

    localparam int NUM_BLOCKS = 64;
    localparam int IDX_W      = $clog2(NUM_BLOCKS);
    localparam int CNT_W      = 7;
    localparam int SIZE_W     = 20;

    localparam logic [1:0] MODE_ALLOC    = 2'd0;
    localparam logic [1:0] MODE_FREE     = 2'd1;
    localparam logic [1:0] MODE_REALLOC  = 2'd2;
    localparam logic [1:0] MODE_RESERVED = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ZERO     = 3'd1;
    localparam logic [2:0] ST_FEW      = 3'd2;
    localparam logic [2:0] ST_NORUN    = 3'd3;
    localparam logic [2:0] ST_BADIDX   = 3'd4;
    localparam logic [2:0] ST_NOTSTART = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CHECK,
        S_SEARCH,
        S_GROW,
        S_MARK,
        S_RELEASE,
        S_SHRINK,
        S_OUT
    } state_t;

endpackage

@@ rtl/contiguous_block_allocator.sv @@
// contiguous block allocator top level: bitmap, run table and sequencer
// One result is delivered per request. A single block index counter walks the used
// bitmap one block per cycle: an allocate scans up to 64 blocks for the first free run
// and then marks the run one block per cycle; a free clears the run one block per cycle.
// s_tready is high only while the block is idle and no result is waiting. The result
// sits in an output register until taken; block_size_log2 is written over the cfg
// channel while idle.
module contiguous_block_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // mode, has_pointer, start_block, request_size, zero pad
    input  logic        m_tready,
    output logic        m_tvalid,
    output logic [31:0] m_tdata    // status, result_block, result_count, moved,
                                   // blocks_in_use, zero pad
);

    localparam int NB = cba_pkg::NUM_BLOCKS;
    localparam int IW = cba_pkg::IDX_W;
    localparam int CW = cba_pkg::CNT_W;

    cba_pkg::state_t state_reg, state_next;

    logic [3:0]  bsl_reg;
    logic [NB-1:0] used_reg, used_next;
    logic [NB-1:0] start_reg, start_next;
    logic [CW-1:0] len_reg [NB];
    logic [CW-1:0] ucnt_reg, ucnt_next;

    logic [1:0]  mode_reg, mode_next;
    logic        ptr_reg, ptr_next;
    logic [IW-1:0] blk_reg, blk_next;
    logic [cba_pkg::SIZE_W-1:0] size_reg, size_next;
    logic [CW-1:0] need_reg, need_next;
    logic [CW-1:0] old_reg, old_next;
    logic [IW:0]   i_reg, i_next;
    logic [CW-1:0] run_reg, run_next;
    logic [IW-1:0] first_reg, first_next;
    logic        move_reg, move_next;

    logic        len_we;
    logic [IW-1:0] len_wa;
    logic [CW-1:0] len_wd;

    logic [2:0]  o_st_reg, o_st_next;
    logic [IW-1:0] o_blk_reg, o_blk_next;
    logic [CW-1:0] o_cnt_reg, o_cnt_next;
    logic        o_mv_reg, o_mv_next;
    logic        mval_reg, mval_next;

    logic [CW-1:0] need_c;
    logic [cba_pkg::SIZE_W:0] need_full;
    logic [cba_pkg::SIZE_W-1:0] mask_c;
    logic [IW-1:0] iw;
    logic [CW-1:0] freec;
    logic [IW+1:0] endp;

    assign iw    = i_reg[IW-1:0];
    assign mask_c = cba_pkg::SIZE_W'((32'd1 << bsl_reg) - 32'd1);
    assign need_full = (cba_pkg::SIZE_W+1)'(size_reg >> bsl_reg)
                     + {{cba_pkg::SIZE_W{1'b0}}, ((size_reg & mask_c) != '0)};
    // counts beyond the 7-bit count range saturate, which keeps every compare correct
    assign need_c = (need_full[cba_pkg::SIZE_W:CW] != '0) ? {CW{1'b1}} : need_full[CW-1:0];
    assign freec = CW'(NB) - ucnt_reg;
    assign endp  = (IW+2)'(blk_reg) + (IW+2)'(need_reg);

    assign cfg_ready = (state_reg == cba_pkg::S_IDLE);
    assign s_tready  = (state_reg == cba_pkg::S_IDLE) && !mval_reg;
    assign m_tvalid  = mval_reg;
    assign m_tdata   = {8'd0, ucnt_reg, o_mv_reg, o_cnt_reg, o_blk_reg, o_st_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cba_pkg::S_IDLE;
            bsl_reg   <= 4'd5;
            used_reg  <= '0;
            start_reg <= '0;
            ucnt_reg  <= '0;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            used_reg  <= used_next;
            start_reg <= start_next;
            ucnt_reg  <= ucnt_next;
            mval_reg  <= mval_next;
            if (cfg_valid && cfg_ready) bsl_reg <= cfg_data;
        end
    end

    // run table, only trusted where the start mark is set
    always_ff @(posedge aclk) begin
        if (len_we) len_reg[len_wa] <= len_wd;
    end

    always_ff @(posedge aclk) begin
        mode_reg  <= mode_next;
        ptr_reg   <= ptr_next;
        blk_reg   <= blk_next;
        size_reg  <= size_next;
        need_reg  <= need_next;
        old_reg   <= old_next;
        i_reg     <= i_next;
        run_reg   <= run_next;
        first_reg <= first_next;
        move_reg  <= move_next;
        o_st_reg  <= o_st_next;
        o_blk_reg <= o_blk_next;
        o_cnt_reg <= o_cnt_next;
        o_mv_reg  <= o_mv_next;
    end

    always_comb begin
        state_next = state_reg;
        used_next = used_reg; start_next = start_reg; ucnt_next = ucnt_reg;
        mval_next = mval_reg;
        mode_next = mode_reg; ptr_next = ptr_reg; blk_next = blk_reg; size_next = size_reg;
        need_next = need_reg; old_next = old_reg; i_next = i_reg; run_next = run_reg;
        first_next = first_reg; move_next = move_reg;
        o_st_next = o_st_reg; o_blk_next = o_blk_reg; o_cnt_next = o_cnt_reg;
        o_mv_next = o_mv_reg;
        len_we = 1'b0; len_wa = blk_reg; len_wd = '0;
        if (mval_reg && m_tready) mval_next = 1'b0;
        case (state_reg)
            cba_pkg::S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    mode_next = s_tdata[1:0];
                    ptr_next  = s_tdata[2];
                    blk_next  = s_tdata[8:3];
                    size_next = s_tdata[28:9];
                    move_next = 1'b0;
                    o_st_next = cba_pkg::ST_OK; o_blk_next = '0;
                    o_cnt_next = '0; o_mv_next = 1'b0;
                    state_next = cba_pkg::S_DECODE;
                end
            end
            cba_pkg::S_DECODE: begin
                need_next = need_c;
                i_next = '0; run_next = '0; first_next = '0;
                if (mode_reg == cba_pkg::MODE_RESERVED) begin
                    o_st_next = cba_pkg::ST_BADIDX; state_next = cba_pkg::S_OUT;
                end else if (mode_reg == cba_pkg::MODE_ALLOC || !ptr_reg) begin
                    if (mode_reg == cba_pkg::MODE_FREE) state_next = cba_pkg::S_OUT;
                    else if (size_reg == '0) begin
                        o_st_next = cba_pkg::ST_ZERO; state_next = cba_pkg::S_OUT;
                    end else if (need_c > freec) begin
                        o_st_next = cba_pkg::ST_FEW; state_next = cba_pkg::S_OUT;
                    end else state_next = cba_pkg::S_SEARCH;
                end else begin
                    old_next = len_reg[blk_reg];
                    state_next = cba_pkg::S_CHECK;
                end
            end
            cba_pkg::S_CHECK: begin
                if (!start_reg[blk_reg] || old_reg == '0
                    || (IW+2)'(old_reg) > (IW+2)'(NB) - (IW+2)'(blk_reg)
                    || old_reg > ucnt_reg) begin
                    o_st_next = cba_pkg::ST_NOTSTART; state_next = cba_pkg::S_OUT;
                end else if (mode_reg == cba_pkg::MODE_FREE || size_reg == '0) begin
                    o_blk_next = blk_reg;
                    i_next = '0;
                    state_next = cba_pkg::S_RELEASE;
                end else if (need_reg <= old_reg) begin
                    i_next = (IW+1)'(blk_reg) + (IW+1)'(need_reg);
                    state_next = cba_pkg::S_SHRINK;
                end else if (endp <= (IW+2)'(NB)) begin
                    i_next = (IW+1)'(blk_reg) + (IW+1)'(old_reg);
                    state_next = cba_pkg::S_GROW;
                end else begin
                    move_next = 1'b1;
                    if (need_reg > freec) begin
                        o_st_next = cba_pkg::ST_FEW; state_next = cba_pkg::S_OUT;
                    end else state_next = cba_pkg::S_SEARCH;
                end
            end
            cba_pkg::S_SHRINK: begin
                if (i_reg >= (IW+1)'(blk_reg) + (IW+1)'(old_reg)) begin
                    len_we = 1'b1; len_wd = need_reg;
                    ucnt_next = ucnt_reg - (old_reg - need_reg);
                    o_blk_next = blk_reg; o_cnt_next = need_reg;
                    state_next = cba_pkg::S_OUT;
                end else begin
                    used_next[iw] = 1'b0;
                    i_next = i_reg + 1'b1;
                end
            end
            cba_pkg::S_GROW: begin
                if ((IW+2)'(i_reg) >= endp) begin
                    // room confirmed: mark in place
                    i_next = (IW+1)'(blk_reg) + (IW+1)'(old_reg);
                    first_next = blk_reg;
                    state_next = cba_pkg::S_MARK;
                end else if (used_reg[iw]) begin
                    move_next = 1'b1;
                    i_next = '0;
                    if (need_reg > freec) begin
                        o_st_next = cba_pkg::ST_FEW; state_next = cba_pkg::S_OUT;
                    end else state_next = cba_pkg::S_SEARCH;
                end else i_next = i_reg + 1'b1;
            end
            cba_pkg::S_SEARCH: begin
                if (i_reg >= (IW+1)'(NB)) begin
                    o_st_next = cba_pkg::ST_NORUN; state_next = cba_pkg::S_OUT;
                end else if (!used_reg[iw]) begin
                    if (run_reg == '0) first_next = iw;
                    run_next = run_reg + 1'b1;
                    if (run_reg + 1'b1 >= need_reg) begin
                        i_next = (run_reg == '0) ? (IW+1)'(iw) : (IW+1)'(first_reg);
                        if (run_reg == '0) first_next = iw;
                        state_next = cba_pkg::S_MARK;
                        old_next = move_reg ? old_reg : '0;
                    end else i_next = i_reg + 1'b1;
                end else begin
                    run_next = '0;
                    i_next = i_reg + 1'b1;
                end
            end
            cba_pkg::S_MARK: begin
                if ((IW+2)'(i_reg) >= (IW+2)'(first_reg) + (IW+2)'(need_reg)) begin
                    len_we = 1'b1; len_wa = first_reg; len_wd = need_reg;
                    o_blk_next = first_reg; o_cnt_next = need_reg;
                    if (move_reg) begin
                        ucnt_next = ucnt_reg + need_reg;
                        o_mv_next = 1'b1;
                        i_next = '0;
                        state_next = cba_pkg::S_RELEASE;
                    end else begin
                        ucnt_next = ucnt_reg + need_reg
                                    - ((first_reg == blk_reg && mode_reg ==
                                        cba_pkg::MODE_REALLOC && ptr_reg) ? old_reg : '0);
                        state_next = cba_pkg::S_OUT;
                    end
                end else begin
                    used_next[iw] = 1'b1;
                    start_next[iw] = ((IW+1)'(first_reg) == i_reg);
                    i_next = i_reg + 1'b1;
                end
            end
            cba_pkg::S_RELEASE: begin
                if (i_reg >= (IW+1)'(old_reg)) begin
                    start_next[blk_reg] = 1'b0;
                    len_we = 1'b1; len_wa = blk_reg; len_wd = '0;
                    ucnt_next = ucnt_reg - old_reg;
                    state_next = cba_pkg::S_OUT;
                end else begin
                    used_next[IW'((IW+1)'(blk_reg) + i_reg)] = 1'b0;
                    i_next = i_reg + 1'b1;
                end
            end
            cba_pkg::S_OUT: begin
                if (!mval_reg) begin
                    mval_next = 1'b1;
                    state_next = cba_pkg::S_IDLE;
                end
            end
            default: state_next = cba_pkg::S_IDLE;
        endcase
    end

endmodule
